// ===== src/smx_pkg.sv =====
// shared constants, opcodes and helpers for the stack machine executor
// no dependencies; used by smx_div and stack_machine_executor
`default_nettype none
package smx_pkg;

   // storage sizes
   localparam int STACK_DEPTH = 256;
   localparam int DATA_WORDS  = 256;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int DATA_AW     = $clog2(DATA_WORDS);

   // field widths
   localparam int WORD_W = 32;
   localparam int IP_W   = 16;
   localparam int STEP_W = 16;

   // configuration registers
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_PROGRAM_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_LIMIT     = 1'd1;
   localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 16'd10000;
   localparam logic [7:0] ADDR_MASK = 8'hFF;

   // opcodes
   localparam int OPC_W = 5;
   localparam logic [OPC_W-1:0] OP_PUSH  = 5'd0;
   localparam logic [OPC_W-1:0] OP_POP   = 5'd1;
   localparam logic [OPC_W-1:0] OP_ADD   = 5'd2;
   localparam logic [OPC_W-1:0] OP_SUB   = 5'd3;
   localparam logic [OPC_W-1:0] OP_MUL   = 5'd4;
   localparam logic [OPC_W-1:0] OP_DIV   = 5'd5;
   localparam logic [OPC_W-1:0] OP_DUP   = 5'd6;
   localparam logic [OPC_W-1:0] OP_SWAP  = 5'd7;
   localparam logic [OPC_W-1:0] OP_NEG   = 5'd8;
   localparam logic [OPC_W-1:0] OP_ABS   = 5'd9;
   localparam logic [OPC_W-1:0] OP_LT    = 5'd10;
   localparam logic [OPC_W-1:0] OP_EQ    = 5'd11;
   localparam logic [OPC_W-1:0] OP_GT    = 5'd12;
   localparam logic [OPC_W-1:0] OP_JMP   = 5'd13;
   localparam logic [OPC_W-1:0] OP_JZ    = 5'd14;
   localparam logic [OPC_W-1:0] OP_JNZ   = 5'd15;
   localparam logic [OPC_W-1:0] OP_LOAD  = 5'd16;
   localparam logic [OPC_W-1:0] OP_SAVE  = 5'd17;
   localparam logic [OPC_W-1:0] OP_NOP   = 5'd18;
   localparam logic [OPC_W-1:0] OP_HALT  = 5'd19;

   // data memory address from a stack word (data words is a power of two)
   function automatic logic [DATA_AW-1:0] data_addr(input logic [WORD_W-1:0] v);
      logic [7:0] low;
      low = v[7:0] & ADDR_MASK;
      return DATA_AW'(low);
   endfunction

   // opcode field of a code word, unknown values fold to nop
   function automatic logic [OPC_W-1:0] decode_op(input logic [WORD_W-1:0] w);
      if (w[WORD_W-1:OPC_W] == '0 && w[OPC_W-1:0] <= OP_HALT) begin
         return w[OPC_W-1:0];
      end
      return OP_NOP;
   endfunction

endpackage
`default_nettype wire

// ===== src/smx_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/smx_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating
// depends on smx_pkg
`default_nettype none
module smx_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [smx_pkg::WORD_W-1:0] dividend,
   input  wire logic [smx_pkg::WORD_W-1:0] divisor,
   output logic                            done,
   output logic [smx_pkg::WORD_W-1:0]      quotient
);

   localparam int W = smx_pkg::WORD_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
         den_in  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
         neg_in  = dividend[W-1] ^ divisor[W-1];
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            q_in    = neg_ff ? (~quo_in + W'(1)) : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

// ===== src/stack_machine_executor.sv =====
// channel | ports                                   | beat
// req     | req_valid req_stall req_op req_operand  | one code word and its operand
//         | req_run_start                           |
// rsp     | rsp_valid rsp_stall rsp_next_ip ...     | machine state after the word
// csr     | csr_wr_en csr_index csr_wr_data         | one register write
//
// a word passes the accept, execute and result states; store with three or more
// entries adds a fill state to refill the cached top from the stack ram.
// div adds a wait state for the bit-serial divider.
// reset is synchronous; data memory valid bits clear at once, no clearing pass.
// a new word is accepted while the previous result still waits on rsp_stall.
// depends on smx_pkg, smx_ram, smx_div
`default_nettype none
module stack_machine_executor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [31:0]            req_op,
   input  wire logic signed [31:0]            req_operand,
   input  wire logic                          req_run_start,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [15:0]                        rsp_next_ip,
   output logic signed [31:0]                 rsp_top_value,
   output logic [8:0]                         rsp_depth,
   output logic                               rsp_executed,
   output logic                               rsp_running,
   output logic [15:0]                        rsp_step_count,
   input  wire logic                          csr_wr_en,
   input  wire logic [smx_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [smx_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   localparam int W   = smx_pkg::WORD_W;
   localparam int SPW = smx_pkg::SP_W;
   localparam int SAW = smx_pkg::STACK_AW;
   localparam int DAW = smx_pkg::DATA_AW;
   localparam int IPW = smx_pkg::IP_W;
   localparam int STW = smx_pkg::STEP_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FILL = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [IPW-1:0] ip_ff, ip_in;
   logic           halt_ff, halt_in;
   logic [STW-1:0] steps_ff, steps_in;
   logic [IPW-1:0] plen_ff, plen_in;
   logic [STW-1:0] limit_ff, limit_in;
   logic [W-1:0]   top_ff, top_in;
   logic [W-1:0]   op_ff, op_in;
   logic [W-1:0]   arg_ff, arg_in;
   logic           run_ff, run_in;
   logic           dok_ff, dok_in;
   logic [smx_pkg::DATA_WORDS-1:0] dvalid_ff, dvalid_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [IPW-1:0] rsp_ip_ff, rsp_ip_in;
   logic [W-1:0]   rsp_top_ff, rsp_top_in;
   logic [SPW-1:0] rsp_sp_ff, rsp_sp_in;
   logic           rsp_exe_ff, rsp_exe_in;
   logic           rsp_run_ff, rsp_run_in;
   logic [STW-1:0] rsp_steps_ff, rsp_steps_in;

   // ram and divider hookup
   logic           stk_we;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [W-1:0]   stk_wdata, stk_rdata;
   logic           dm_we;
   logic [DAW-1:0] dm_waddr, dm_raddr;
   logic [W-1:0]   dm_wdata, dm_rdata;
   logic           div_start, div_done;
   logic [W-1:0]   div_q;

   // working values
   logic [SPW-1:0] sp_m1, sp_m2, sp_m3;
   logic [IPW-1:0] ip1;
   logic           have_arg;
   logic [smx_pkg::OPC_W-1:0] opc;
   logic [W-1:0]   second;
   logic [W-1:0]   mul_res;
   logic [STW-1:0] steps_eff;
   logic           out_free;

   smx_ram #(.WIDTH(W), .DEPTH(smx_pkg::STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   smx_ram #(.WIDTH(W), .DEPTH(smx_pkg::DATA_WORDS)) u_data (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   smx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (stk_rdata),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sp_m1    = sp_ff - SPW'(1);
   assign sp_m2    = sp_ff - SPW'(2);
   assign sp_m3    = sp_ff - SPW'(3);
   assign ip1      = ip_ff + IPW'(1);
   assign have_arg = ip1 < plen_ff;
   assign opc      = smx_pkg::decode_op(op_ff);
   assign second   = stk_rdata;
   assign mul_res  = second * top_ff;
   assign steps_eff = req_run_start ? '0 : steps_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // read addresses: second entry on accept, refill entry during execute
   assign stk_raddr = (state_ff == S_EXEC) ? sp_m3[SAW-1:0] : sp_m2[SAW-1:0];
   assign dm_raddr  = smx_pkg::data_addr(top_ff);

   // sequencer and execute step
   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      ip_in     = ip_ff;
      halt_in   = halt_ff;
      steps_in  = steps_ff;
      top_in    = top_ff;
      op_in     = op_ff;
      arg_in    = arg_ff;
      run_in    = run_ff;
      dok_in    = dok_ff;
      dvalid_in = dvalid_ff;
      plen_in   = plen_ff;
      limit_in  = limit_ff;
      stk_we    = 1'b0;
      stk_waddr = sp_m1[SAW-1:0];
      stk_wdata = top_ff;
      dm_we     = 1'b0;
      dm_waddr  = smx_pkg::data_addr(second);
      dm_wdata  = top_ff;
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_ip_in    = rsp_ip_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_sp_in    = rsp_sp_ff;
      rsp_exe_in   = rsp_exe_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_steps_in = rsp_steps_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            smx_pkg::REG_PROGRAM_LENGTH: plen_in  = csr_wr_data;
            smx_pkg::REG_STEP_LIMIT:     limit_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               arg_in   = req_operand;
               steps_in = steps_eff;
               run_in   = !halt_ff && (ip_ff < plen_ff) && (steps_eff < limit_ff);
               dok_in   = dvalid_ff[dm_raddr];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            if (run_ff) begin
               ip_in    = ip1;
               steps_in = steps_ff + STW'(1);
               unique case (opc)
                  smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
                  smx_pkg::OP_LT, smx_pkg::OP_EQ, smx_pkg::OP_GT: begin
                     if (sp_ff >= SPW'(2)) begin
                        sp_in = sp_m1;
                        unique case (opc)
                           smx_pkg::OP_ADD: top_in = second + top_ff;
                           smx_pkg::OP_SUB: top_in = second - top_ff;
                           smx_pkg::OP_MUL: top_in = mul_res;
                           smx_pkg::OP_LT:
                              top_in = W'($signed(second) < $signed(top_ff));
                           smx_pkg::OP_EQ:  top_in = W'(second == top_ff);
                           default:
                              top_in = W'($signed(top_ff) < $signed(second));
                        endcase
                     end
                  end
                  smx_pkg::OP_DIV: begin
                     if (sp_ff >= SPW'(2) && top_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  smx_pkg::OP_SWAP: begin
                     if (sp_ff >= SPW'(2)) begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_m2[SAW-1:0];
                        stk_wdata = top_ff;
                        top_in    = second;
                     end
                  end
                  smx_pkg::OP_PUSH: begin
                     if (have_arg && sp_ff < SPW'(smx_pkg::STACK_DEPTH)) begin
                        stk_we = (sp_ff != '0);
                        top_in = arg_ff;
                        sp_in  = sp_ff + SPW'(1);
                        ip_in  = ip1 + IPW'(1);
                     end
                  end
                  smx_pkg::OP_POP: begin
                     if (sp_ff != '0) begin
                        sp_in  = sp_m1;
                        top_in = second;
                     end
                  end
                  smx_pkg::OP_DUP: begin
                     if (sp_ff != '0 && sp_ff < SPW'(smx_pkg::STACK_DEPTH)) begin
                        stk_we = 1'b1;
                        sp_in  = sp_ff + SPW'(1);
                     end
                  end
                  smx_pkg::OP_NEG: begin
                     if (sp_ff != '0) begin
                        top_in = ~top_ff + W'(1);
                     end
                  end
                  smx_pkg::OP_ABS: begin
                     if (sp_ff != '0 && top_ff[W-1]) begin
                        top_in = ~top_ff + W'(1);
                     end
                  end
                  smx_pkg::OP_JMP: begin
                     if (have_arg) begin
                        if (arg_ff[W-1:IPW] == '0) begin
                           ip_in = arg_ff[IPW-1:0];
                        end else begin
                           halt_in = 1'b1;
                        end
                     end
                  end
                  smx_pkg::OP_JZ, smx_pkg::OP_JNZ: begin
                     if (have_arg && sp_ff != '0) begin
                        sp_in  = sp_m1;
                        top_in = second;
                        if ((top_ff == '0) == (opc == smx_pkg::OP_JZ)) begin
                           if (arg_ff[W-1:IPW] == '0) begin
                              ip_in = arg_ff[IPW-1:0];
                           end else begin
                              halt_in = 1'b1;
                           end
                        end else begin
                           ip_in = ip1 + IPW'(1);
                        end
                     end
                  end
                  smx_pkg::OP_LOAD: begin
                     if (sp_ff != '0) begin
                        top_in = dok_ff ? dm_rdata : '0;
                     end
                  end
                  smx_pkg::OP_SAVE: begin
                     if (sp_ff >= SPW'(2)) begin
                        dm_we = 1'b1;
                        dvalid_in[dm_waddr] = 1'b1;
                        sp_in = sp_m2;
                        if (sp_ff >= SPW'(3)) begin
                           state_in = S_FILL;
                        end
                     end
                  end
                  smx_pkg::OP_HALT: halt_in = 1'b1;
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               top_in   = div_q;
               sp_in    = sp_m1;
               state_in = S_OUT;
            end
         end
         S_FILL: begin
            top_in   = stk_rdata;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ip_in    = ip_ff;
               rsp_top_in   = (sp_ff != '0) ? top_ff : '0;
               rsp_sp_in    = sp_ff;
               rsp_exe_in   = run_ff;
               rsp_run_in   = !halt_ff && (ip_ff < plen_ff) && (steps_ff < limit_ff);
               rsp_steps_in = steps_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         ip_ff        <= '0;
         halt_ff      <= 1'b0;
         steps_ff     <= '0;
         plen_ff      <= '0;
         limit_ff     <= smx_pkg::STEP_LIMIT_RESET;
         dvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         ip_ff        <= ip_in;
         halt_ff      <= halt_in;
         steps_ff     <= steps_in;
         plen_ff      <= plen_in;
         limit_ff     <= limit_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff       <= top_in;
      op_ff        <= op_in;
      arg_ff       <= arg_in;
      run_ff       <= run_in;
      dok_ff       <= dok_in;
      rsp_ip_ff    <= rsp_ip_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_sp_ff    <= rsp_sp_in;
      rsp_exe_ff   <= rsp_exe_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_steps_ff <= rsp_steps_in;
   end

   // result beat
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_ip    = rsp_ip_ff;
   assign rsp_top_value  = rsp_top_ff;
   assign rsp_depth      = rsp_sp_ff;
   assign rsp_executed   = rsp_exe_ff;
   assign rsp_running    = rsp_run_ff;
   assign rsp_step_count = rsp_steps_ff;

endmodule
`default_nettype wire
